// ----- hdl/sbc_pkg.sv -----
// shared types, constants and command/config structs for the stereo bit crusher
`timescale 1ns / 1ps

package sbc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int PHASE_BITS  = 24;

    localparam int BD_BITS       = 5;
    localparam int GAIN_BITS     = 16;
    localparam int WET_BITS      = 16;
    localparam int SHIFT_BITS    = 5;
    localparam int GAIN_FRAC     = 12;
    localparam int MIX_FRAC      = 15;
    localparam int MUL_A_BITS    = SAMPLE_BITS + 1;
    localparam int MUL_B_BITS    = GAIN_BITS + 1;
    localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BIT_DEPTH  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_INC  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRIVE_GAIN = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WET_LEVEL  = 3'd4;

    localparam logic [PHASE_BITS:0]  PHASE_ONE     = {1'b1, {PHASE_BITS{1'b0}}};
    localparam logic [WET_BITS-1:0]  WET_ONE       = 16'h8000;
    localparam logic [GAIN_BITS-1:0] GAIN_UNITY    = 16'h1000;
    localparam logic [BD_BITS-1:0]   BIT_DEPTH_RST = 5'd16;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } out_t;

    typedef struct packed {
        logic                 enable;
        logic [BD_BITS-1:0]   crush_bits;
        logic [PHASE_BITS:0]  phase_inc;
        logic [GAIN_BITS-1:0] drive_gain;
        logic [WET_BITS-1:0]  wet_level;
    } cfg_t;

    typedef enum logic [1:0] {
        MUL_DRV_L,
        MUL_DRV_R,
        MUL_MIX_L,
        MUL_MIX_R
    } mul_sel_t;

    typedef struct packed {
        logic     take_in;
        mul_sel_t mul_sel;
        logic     mul_en;
        logic     drv_l_en;
        logic     capture;
        logic     crush_r;
        logic     mix_l_en;
        logic     load_out;
    } cmd_t;

endpackage

// ----- hdl/sbc_datapath.sv -----
// datapath: shared multiplier, drive, phase/hold, crush and mix registers
`timescale 1ns / 1ps

module sbc_datapath (
    input  logic          aclk,
    input  logic          aresetn,
    input  sbc_pkg::cfg_t cfg,
    input  sbc_pkg::cmd_t cmd,
    input  sbc_pkg::in_t  s_data,
    output sbc_pkg::out_t m_data
);

    localparam int SB = sbc_pkg::SAMPLE_BITS;
    localparam int PB = sbc_pkg::PHASE_BITS;
    localparam int PW = sbc_pkg::PROD_BITS;
    localparam int SW = sbc_pkg::SHIFT_BITS;

    // clamp a wide value to full scale
    function automatic logic signed [SB-1:0] sat_w(input logic signed [PW-1:0] v);
        logic [PW-SB:0] hi;
        hi = v[PW-1:SB-1];
        if ((&hi) || (~|hi)) begin
            return v[SB-1:0];
        end else if (v[PW-1]) begin
            return {1'b1, {(SB-1){1'b0}}};
        end else begin
            return {1'b0, {(SB-1){1'b1}}};
        end
    endfunction

    // bias for round half away from zero before a floor shift
    function automatic logic signed [PW-1:0] rnd_bias(input logic neg, input logic [SW-1:0] s);
        logic signed [PW-1:0] b;
        if (s == '0) begin
            b = '0;
        end else begin
            b = (PW'(1) << (s - SW'(1))) - PW'(neg);
        end
        return b;
    endfunction

    function automatic logic signed [PW-1:0] rnd_half(input logic signed [PW-1:0] v,
                                                       input logic [SW-1:0] s);
        logic signed [PW-1:0] t;
        t = v + rnd_bias(v[PW-1], s);
        return t >>> s;
    endfunction

    function automatic logic signed [SB-1:0] drive_fin(input logic signed [PW-1:0] p);
        return sat_w(rnd_half(p, SW'(sbc_pkg::GAIN_FRAC)));
    endfunction

    function automatic logic signed [SB-1:0] mix_fin(input logic signed [PW-1:0] p,
                                                      input logic signed [SB-1:0] x);
        logic signed [PW-1:0] sum;
        sum = p + (PW'(x) <<< sbc_pkg::MIX_FRAC);
        return sat_w(rnd_half(sum, SW'(sbc_pkg::MIX_FRAC)));
    endfunction

    // round then clear the dropped bits, same as rnd(h, s) << s
    function automatic logic signed [SB-1:0] crush(input logic signed [SB-1:0] h,
                                                    input logic [SW-1:0] s);
        logic signed [PW-1:0] t;
        logic [PW-1:0]        msk;
        t   = PW'(h) + rnd_bias(h[SB-1], s);
        msk = ~((PW'(1) << s) - PW'(1));
        return sat_w(t & msk);
    endfunction

    logic signed [SB-1:0] xl_reg, xl_next, xr_reg, xr_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [SB-1:0] dl_reg, dl_next;
    logic signed [SB-1:0] held_l_reg, held_l_next, held_r_reg, held_r_next;
    logic signed [SB-1:0] cl_reg, cl_next, cr_reg, cr_next;
    logic signed [SB-1:0] mix_l_reg, mix_l_next;
    logic [PB-1:0]        phase_reg, phase_next;
    sbc_pkg::out_t        out_reg, out_next;

    logic [sbc_pkg::BD_BITS-1:0]  depth;
    logic [SW-1:0]                shift;
    logic [sbc_pkg::WET_BITS-1:0] wet_eff;
    logic [PB+1:0]                acc;
    logic                         wrap;

    logic signed [sbc_pkg::MUL_A_BITS-1:0] mul_a;
    logic signed [sbc_pkg::MUL_B_BITS-1:0] mul_b;

    always_comb begin
        if (cfg.crush_bits == '0) begin
            depth = sbc_pkg::BD_BITS'(1);
        end else if ({1'b0, cfg.crush_bits} > (sbc_pkg::BD_BITS + 1)'(SB)) begin
            depth = sbc_pkg::BD_BITS'(SB);
        end else begin
            depth = cfg.crush_bits;
        end
        shift   = SW'(SB) - SW'(depth);
        wet_eff = (cfg.wet_level > sbc_pkg::WET_ONE) ? sbc_pkg::WET_ONE : cfg.wet_level;
        acc     = {2'b00, phase_reg} + {1'b0, cfg.phase_inc};
        wrap    = |acc[PB+1:PB];
    end

    always_comb begin
        unique case (cmd.mul_sel)
            sbc_pkg::MUL_DRV_L: begin
                mul_a = sbc_pkg::MUL_A_BITS'(xl_reg);
                mul_b = $signed({1'b0, cfg.drive_gain});
            end
            sbc_pkg::MUL_DRV_R: begin
                mul_a = sbc_pkg::MUL_A_BITS'(xr_reg);
                mul_b = $signed({1'b0, cfg.drive_gain});
            end
            sbc_pkg::MUL_MIX_L: begin
                mul_a = sbc_pkg::MUL_A_BITS'(cl_reg) - sbc_pkg::MUL_A_BITS'(xl_reg);
                mul_b = $signed({1'b0, wet_eff});
            end
            sbc_pkg::MUL_MIX_R: begin
                mul_a = sbc_pkg::MUL_A_BITS'(cr_reg) - sbc_pkg::MUL_A_BITS'(xr_reg);
                mul_b = $signed({1'b0, wet_eff});
            end
        endcase
    end

    always_comb begin
        xl_next     = xl_reg;
        xr_next     = xr_reg;
        prod_next   = prod_reg;
        dl_next     = dl_reg;
        held_l_next = held_l_reg;
        held_r_next = held_r_reg;
        cl_next     = cl_reg;
        cr_next     = cr_reg;
        mix_l_next  = mix_l_reg;
        phase_next  = phase_reg;
        out_next    = out_reg;

        if (cmd.take_in) begin
            xl_next = s_data.left_sample;
            xr_next = s_data.right_sample;
        end
        if (cmd.mul_en) begin
            prod_next = mul_a * mul_b;
        end
        if (cmd.drv_l_en) begin
            dl_next = drive_fin(prod_reg);
        end
        if (cmd.capture) begin
            // product register holds the right channel drive here
            phase_next  = acc[PB-1:0];
            held_l_next = wrap ? dl_reg : held_l_reg;
            held_r_next = wrap ? drive_fin(prod_reg) : held_r_reg;
            cl_next     = crush(held_l_next, shift);
        end
        if (cmd.crush_r) begin
            cr_next = crush(held_r_reg, shift);
        end
        if (cmd.mix_l_en) begin
            mix_l_next = mix_fin(prod_reg, xl_reg);
        end
        if (cmd.load_out) begin
            if (!cfg.enable) begin
                out_next.left_out  = xl_reg;
                out_next.right_out = xr_reg;
            end else begin
                out_next.left_out  = mix_l_reg;
                out_next.right_out = mix_fin(prod_reg, xr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            held_l_reg <= '0;
            held_r_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            held_l_reg <= held_l_next;
            held_r_reg <= held_r_next;
        end
    end

    always_ff @(posedge aclk) begin
        xl_reg    <= xl_next;
        xr_reg    <= xr_next;
        prod_reg  <= prod_next;
        dl_reg    <= dl_next;
        cl_reg    <= cl_next;
        cr_reg    <= cr_next;
        mix_l_reg <= mix_l_next;
        out_reg   <= out_next;
    end

    assign m_data = out_reg;

endmodule

// ----- hdl/sbc_ctrl.sv -----
// controller: sequences one frame through the datapath and runs both handshakes
`timescale 1ns / 1ps

module sbc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          enable,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output sbc_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DRV_L = 7'b0000010,
        S_DRV_R = 7'b0000100,
        S_CAP   = 7'b0001000,
        S_MIX_L = 7'b0010000,
        S_MIX_R = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = sbc_pkg::MUL_DRV_L;
        s_ready     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_in = 1'b1;
                    state_next  = enable ? S_DRV_L : S_DONE;
                end
            end
            S_DRV_L: begin
                cmd.mul_sel = sbc_pkg::MUL_DRV_L;
                cmd.mul_en  = 1'b1;
                state_next  = S_DRV_R;
            end
            S_DRV_R: begin
                cmd.drv_l_en = 1'b1;
                cmd.mul_sel  = sbc_pkg::MUL_DRV_R;
                cmd.mul_en   = 1'b1;
                state_next   = S_CAP;
            end
            S_CAP: begin
                cmd.capture = 1'b1;
                state_next  = S_MIX_L;
            end
            S_MIX_L: begin
                cmd.mul_sel = sbc_pkg::MUL_MIX_L;
                cmd.mul_en  = 1'b1;
                cmd.crush_r = 1'b1;
                state_next  = S_MIX_R;
            end
            S_MIX_R: begin
                cmd.mix_l_en = 1'b1;
                cmd.mul_sel  = sbc_pkg::MUL_MIX_R;
                cmd.mul_en   = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                // result goes out and the next beat can come in together
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    s_ready      = 1'b1;
                    if (s_valid) begin
                        cmd.take_in = 1'b1;
                        state_next  = enable ? S_DRV_L : S_DONE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("output register loaded while a beat is still waiting");

    a_ready_states: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_IDLE || state_reg == S_DONE))
        else $error("input ready raised in the middle of a frame");

    a_enabled_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && enable) |=> (state_reg == S_DRV_L))
        else $error("accepted beat did not start the drive step");

    a_bypass_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !enable) |=> (state_reg == S_DONE))
        else $error("bypassed beat did not go straight to output");

endmodule

// ----- hdl/stereo_bitcrusher_unit.sv -----
// stereo bit crusher top level: config registers, controller and datapath
// sequence: enabled frames step through S_DRV_L, S_DRV_R, S_CAP, S_MIX_L, S_MIX_R, S_DONE;
//   disabled frames go straight to S_DONE. A new frame is taken only in S_IDLE or S_DONE,
//   as the single 25x17 multiplier serves two drive products and two mix products per frame
// disabled frames pass through at one per cycle while m_ready keeps the output free
// reset: config returns to its defaults, phase and held samples clear, no output pending
`timescale 1ns / 1ps

module stereo_bitcrusher_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  sbc_pkg::in_t                          s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output sbc_pkg::out_t                         m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sbc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [sbc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    sbc_pkg::cfg_t cfg_reg, cfg_next;
    sbc_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                sbc_pkg::CFG_ENABLE: begin
                    cfg_next.enable = cfg_data[0];
                end
                sbc_pkg::CFG_BIT_DEPTH: begin
                    cfg_next.crush_bits = cfg_data[sbc_pkg::BD_BITS-1:0];
                end
                sbc_pkg::CFG_PHASE_INC: begin
                    cfg_next.phase_inc = cfg_data[sbc_pkg::PHASE_BITS:0];
                end
                sbc_pkg::CFG_DRIVE_GAIN: begin
                    cfg_next.drive_gain = cfg_data[sbc_pkg::GAIN_BITS-1:0];
                end
                sbc_pkg::CFG_WET_LEVEL: begin
                    cfg_next.wet_level = cfg_data[sbc_pkg::WET_BITS-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable     <= 1'b1;
            cfg_reg.crush_bits <= sbc_pkg::BIT_DEPTH_RST;
            cfg_reg.phase_inc  <= sbc_pkg::PHASE_ONE;
            cfg_reg.drive_gain <= sbc_pkg::GAIN_UNITY;
            cfg_reg.wet_level  <= sbc_pkg::WET_ONE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enable  (cfg_reg.enable),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    sbc_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule
